### rtl/core/tlpcq_pkg.sv
// Shared types, codes and defaults for the two-level priority command queue.
// No dependencies; used by tlpcq_ctrl, tlpcq_dp and the top level.
package tlpcq_pkg;

   localparam int unsigned PRIO_DEPTH_DEFAULT    = 8;
   localparam int unsigned GENERAL_DEPTH_DEFAULT = 32;
   localparam int unsigned DATA_WIDTH_DEFAULT    = 64;

   // opcodes
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_SERVICE = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_ENQUEUED   = 2'd0;
   localparam logic [1:0] KIND_DROPPED    = 2'd1;
   localparam logic [1:0] KIND_DISPATCHED = 2'd2;
   localparam logic [1:0] KIND_NOTHING    = 2'd3;

   typedef struct packed {
      logic        opcode;
      logic        is_priority;
      logic [7:0]  request_code;
      logic [63:0] command_data;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic        from_priority;
      logic [7:0]  out_request_code;
      logic [63:0] out_command_data;
      logic        last;
   } rsp_payload_type;

   // controller -> datapath
   typedef struct packed {
      logic push;        // enqueue request accepted
      logic pop_prio;    // read and retire priority head
      logic pop_gen;     // read and retire general head
      logic emit_entry;  // load fetched entry into output register
      logic emit_none;   // load nothing-to-dispatch result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic prio_empty;
      logic gen_empty;
      logic out_free;
      logic emit_last;
   } status_type;

endpackage

### rtl/core/tlpcq_ctrl.sv
// Sequencer for the two-level priority command queue.
// Depends on tlpcq_pkg (cmd_type, status_type, opcodes).
module tlpcq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_opcode,
   input  tlpcq_pkg::status_type sts,
   output logic                 req_stall,
   output tlpcq_pkg::cmd_type   cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE) || !sts.out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == tlpcq_pkg::OP_ENQUEUE) begin
                  cmd.push = 1'b1;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            priority if (!sts.prio_empty) begin
               cmd.pop_prio = 1'b1;
               state_in     = ST_EMIT;
            end else if (!sts.gen_empty) begin
               cmd.pop_gen = 1'b1;
               state_in    = ST_EMIT;
            end else if (sts.out_free) begin
               cmd.emit_none = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_entry = 1'b1;
               state_in       = sts.emit_last ? ST_IDLE : ST_FETCH;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/tlpcq_dp.sv
// Datapath: both ring stores, their pointers, read registers and the result register.
// Depends on tlpcq_pkg (payload, cmd and status types, result kinds).
module tlpcq_dp #(
   parameter int unsigned PRIO_DEPTH    = tlpcq_pkg::PRIO_DEPTH_DEFAULT,
   parameter int unsigned GENERAL_DEPTH = tlpcq_pkg::GENERAL_DEPTH_DEFAULT,
   parameter int unsigned DATA_WIDTH    = tlpcq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tlpcq_pkg::req_payload_type req_payload,
   input  logic                      rsp_stall,
   input  tlpcq_pkg::cmd_type        cmd,
   output tlpcq_pkg::status_type     sts,
   output logic                      rsp_valid,
   output tlpcq_pkg::rsp_payload_type rsp_payload
);

   localparam int unsigned EW  = 8 + DATA_WIDTH;
   localparam int unsigned PPW = (PRIO_DEPTH > 1) ? $clog2(PRIO_DEPTH) : 1;
   localparam int unsigned PCW = $clog2(PRIO_DEPTH + 1);
   localparam int unsigned GPW = (GENERAL_DEPTH > 1) ? $clog2(GENERAL_DEPTH) : 1;
   localparam int unsigned GCW = $clog2(GENERAL_DEPTH + 1);
   localparam int unsigned PTW = PPW + 1;
   localparam int unsigned GTW = GPW + 1;

   localparam logic [PPW-1:0] PRIO_LAST  = PPW'(PRIO_DEPTH - 1);
   localparam logic [GPW-1:0] GEN_LAST   = GPW'(GENERAL_DEPTH - 1);
   localparam logic [PCW-1:0] PRIO_FULL  = PCW'(PRIO_DEPTH);
   localparam logic [GCW-1:0] GEN_FULL   = GCW'(GENERAL_DEPTH);
   localparam logic [PTW-1:0] PRIO_SPAN  = PTW'(PRIO_DEPTH);
   localparam logic [GTW-1:0] GEN_SPAN   = GTW'(GENERAL_DEPTH);

   logic [EW-1:0]  prio_mem [PRIO_DEPTH];
   logic [EW-1:0]  gen_mem  [GENERAL_DEPTH];

   logic [PPW-1:0] prio_head_ff, prio_head_in;
   logic [PCW-1:0] prio_count_ff, prio_count_in;
   logic [GPW-1:0] gen_head_ff, gen_head_in;
   logic [GCW-1:0] gen_count_ff, gen_count_in;

   logic [EW-1:0]  rd_data_ff;
   logic           src_prio_ff;

   logic           rsp_valid_ff, rsp_valid_in;
   tlpcq_pkg::rsp_payload_type rsp_payload_ff;

   logic [PTW-1:0] prio_sum;
   logic [GTW-1:0] gen_sum;
   logic [PPW-1:0] prio_tail;
   logic [GPW-1:0] gen_tail;
   logic           prio_full, gen_full;
   logic           push_ok;
   logic [EW-1:0]  wr_entry;

   assign prio_full = (prio_count_ff == PRIO_FULL);
   assign gen_full  = (gen_count_ff == GEN_FULL);
   assign push_ok   = req_payload.is_priority ? !prio_full : !gen_full;
   assign wr_entry  = {req_payload.request_code, req_payload.command_data[DATA_WIDTH-1:0]};

   // tail = head + count, wrapped once
   always_comb begin
      prio_sum = PTW'(prio_head_ff) + PTW'(prio_count_ff);
      if (prio_sum >= PRIO_SPAN) begin
         prio_sum = prio_sum - PRIO_SPAN;
      end
      prio_tail = prio_sum[PPW-1:0];
      gen_sum = GTW'(gen_head_ff) + GTW'(gen_count_ff);
      if (gen_sum >= GEN_SPAN) begin
         gen_sum = gen_sum - GEN_SPAN;
      end
      gen_tail = gen_sum[GPW-1:0];
   end

   always_comb begin
      prio_head_in  = prio_head_ff;
      prio_count_in = prio_count_ff;
      gen_head_in   = gen_head_ff;
      gen_count_in  = gen_count_ff;
      if (cmd.push && push_ok) begin
         if (req_payload.is_priority) begin
            prio_count_in = prio_count_ff + 1'b1;
         end else begin
            gen_count_in = gen_count_ff + 1'b1;
         end
      end
      if (cmd.pop_prio) begin
         prio_head_in  = (prio_head_ff == PRIO_LAST) ? '0 : prio_head_ff + 1'b1;
         prio_count_in = prio_count_ff - 1'b1;
      end
      if (cmd.pop_gen) begin
         gen_head_in  = (gen_head_ff == GEN_LAST) ? '0 : gen_head_ff + 1'b1;
         gen_count_in = gen_count_ff - 1'b1;
      end
   end

   assign rsp_valid_in = cmd.push || cmd.emit_none || cmd.emit_entry ||
                         (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         prio_head_ff  <= '0;
         prio_count_ff <= '0;
         gen_head_ff   <= '0;
         gen_count_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         prio_head_ff  <= prio_head_in;
         prio_count_ff <= prio_count_in;
         gen_head_ff   <= gen_head_in;
         gen_count_ff  <= gen_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // stores: one write, one registered read each
   always_ff @(posedge clock) begin
      if (cmd.push && push_ok && req_payload.is_priority) begin
         prio_mem[prio_tail] <= wr_entry;
      end
      if (cmd.push && push_ok && !req_payload.is_priority) begin
         gen_mem[gen_tail] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop_prio) begin
         rd_data_ff  <= prio_mem[prio_head_ff];
         src_prio_ff <= 1'b1;
      end else if (cmd.pop_gen) begin
         rd_data_ff  <= gen_mem[gen_head_ff];
         src_prio_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_payload_ff.result_kind      <= push_ok ? tlpcq_pkg::KIND_ENQUEUED
                                                    : tlpcq_pkg::KIND_DROPPED;
         rsp_payload_ff.from_priority    <= req_payload.is_priority;
         rsp_payload_ff.out_request_code <= '0;
         rsp_payload_ff.out_command_data <= '0;
         rsp_payload_ff.last             <= 1'b1;
      end else if (cmd.emit_none) begin
         rsp_payload_ff.result_kind      <= tlpcq_pkg::KIND_NOTHING;
         rsp_payload_ff.from_priority    <= 1'b0;
         rsp_payload_ff.out_request_code <= '0;
         rsp_payload_ff.out_command_data <= '0;
         rsp_payload_ff.last             <= 1'b1;
      end else if (cmd.emit_entry) begin
         rsp_payload_ff.result_kind      <= tlpcq_pkg::KIND_DISPATCHED;
         rsp_payload_ff.from_priority    <= src_prio_ff;
         rsp_payload_ff.out_request_code <= rd_data_ff[EW-1:DATA_WIDTH];
         rsp_payload_ff.out_command_data <= 64'(rd_data_ff[DATA_WIDTH-1:0]);
         rsp_payload_ff.last             <= sts.emit_last;
      end
   end

   // a general entry always ends the run; a priority one ends it when both queues are dry
   assign sts.emit_last  = !src_prio_ff || ((prio_count_ff == '0) && (gen_count_ff == '0));
   assign sts.prio_empty = (prio_count_ff == '0);
   assign sts.gen_empty  = (gen_count_ff == '0);
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### rtl/core/two_level_priority_command_queue_top.sv
// Top level of the two-level priority command queue.
// Depends on tlpcq_pkg, tlpcq_ctrl and tlpcq_dp.
//
// Usage:
//  - req_ channel carries one request: an enqueue (opcode 0) or a service
//    tick (opcode 1). Taken on a clock edge with req_valid high, req_stall low.
//  - rsp_ channel returns results through a single output register; a result
//    is taken on an edge with rsp_valid high and rsp_stall low.
//  - Enqueue: one result, registered the cycle after acceptance; the next
//    request can be taken in that same cycle, so enqueues run at one per
//    cycle while the receiver keeps up.
//  - Service tick: every priority entry, oldest first, then at most one
//    general entry; each result is a registered store read, then a load of
//    the output register once it is free. The final result has last set. A
//    tick with both queues empty gives one "nothing to dispatch" result.
//  - req_stall stays high for the whole tick and whenever the output register
//    is held by rsp_stall; nothing is lost or repeated under stall.
//  - Reset (synchronous) empties both queues and clears rsp_valid; no
//    clearing pass is needed, the stores are only read where written.
module two_level_priority_command_queue_top #(
   parameter int unsigned PRIO_DEPTH    = tlpcq_pkg::PRIO_DEPTH_DEFAULT,
   parameter int unsigned GENERAL_DEPTH = tlpcq_pkg::GENERAL_DEPTH_DEFAULT,
   parameter int unsigned DATA_WIDTH    = tlpcq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  tlpcq_pkg::req_payload_type req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output tlpcq_pkg::rsp_payload_type rsp_payload
);

   tlpcq_pkg::cmd_type    cmd;
   tlpcq_pkg::status_type sts;

   // sequencer: decides push / pop / emit each cycle
   tlpcq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_payload.opcode),
      .sts        (sts),
      .req_stall  (req_stall),
      .cmd        (cmd)
   );

   // stores, ring pointers and the output register
   tlpcq_dp #(
      .PRIO_DEPTH    (PRIO_DEPTH),
      .GENERAL_DEPTH (GENERAL_DEPTH),
      .DATA_WIDTH    (DATA_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for two_level_priority_command_queue_top.
// Depends on tlpcq_pkg and the RTL; a scoreboard class predicts every result.

module tb_top;

   localparam int unsigned PRIO_SLOTS = tlpcq_pkg::PRIO_DEPTH_DEFAULT;
   localparam int unsigned GEN_SLOTS  = tlpcq_pkg::GENERAL_DEPTH_DEFAULT;
   localparam logic [63:0] DATA_MASK  = (tlpcq_pkg::DATA_WIDTH_DEFAULT >= 64) ? '1 :
                                        ((64'd1 << tlpcq_pkg::DATA_WIDTH_DEFAULT) - 64'd1);
   // worst service tick: every priority slot plus one general entry
   localparam int unsigned TICK_CYCLES = 2 * PRIO_SLOTS + 3;

   // one queued command as held in either ring
   typedef struct packed {
      logic [7:0]  code;
      logic [63:0] data;
   } queued_cmd_type;

   // Mirrors both rings and holds the results still owed by the block, oldest first.
   class dispatch_scoreboard;
      queued_cmd_type  prio_ring[PRIO_SLOTS];
      queued_cmd_type  gen_ring[GEN_SLOTS];
      int unsigned     prio_head, prio_fill, gen_head, gen_fill;
      tlpcq_pkg::rsp_payload_type owed_results[$];
      int unsigned     mismatches, results;
      int unsigned     kind_count[4];

      function int unsigned outstanding();
         return owed_results.size();
      endfunction

      // Called once per accepted request; queues the results it must cause.
      function void note_request(tlpcq_pkg::req_payload_type req);
         queued_cmd_type  cmd;
         tlpcq_pkg::rsp_payload_type res;
         int unsigned     total, i;
         cmd.code = req.request_code;
         cmd.data = req.command_data & DATA_MASK;
         res = '0;
         if (req.opcode == tlpcq_pkg::OP_ENQUEUE) begin
            res.from_priority = req.is_priority;
            res.last          = 1'b1;
            res.result_kind   = tlpcq_pkg::KIND_DROPPED;
            if (req.is_priority && prio_fill < PRIO_SLOTS) begin
               prio_ring[(prio_head + prio_fill) % PRIO_SLOTS] = cmd;
               prio_fill++;
               res.result_kind = tlpcq_pkg::KIND_ENQUEUED;
            end else if (!req.is_priority && gen_fill < GEN_SLOTS) begin
               gen_ring[(gen_head + gen_fill) % GEN_SLOTS] = cmd;
               gen_fill++;
               res.result_kind = tlpcq_pkg::KIND_ENQUEUED;
            end
            owed_results.push_back(res);
         end else begin
            // drain all priority entries, then at most one general entry
            total = prio_fill + ((gen_fill != 0) ? 1 : 0);
            if (total == 0) begin
               res.result_kind = tlpcq_pkg::KIND_NOTHING;
               res.last        = 1'b1;
               owed_results.push_back(res);
            end
            for (i = 0; i < total; i++) begin
               res = '0;
               res.result_kind = tlpcq_pkg::KIND_DISPATCHED;
               res.last        = (i == total - 1);
               if (prio_fill != 0) begin
                  cmd               = prio_ring[prio_head];
                  res.from_priority = 1'b1;
                  prio_head         = (prio_head + 1) % PRIO_SLOTS;
                  prio_fill--;
               end else begin
                  cmd      = gen_ring[gen_head];
                  gen_head = (gen_head + 1) % GEN_SLOTS;
                  gen_fill--;
               end
               res.out_request_code = cmd.code;
               res.out_command_data = cmd.data;
               owed_results.push_back(res);
            end
         end
      endfunction

      function void report_mismatch(string what, tlpcq_pkg::rsp_payload_type want,
                                    tlpcq_pkg::rsp_payload_type got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t %s: want kind=%0d prio=%0b code=%02h data=%016h last=%0b",
                     $time, what, want.result_kind, want.from_priority,
                     want.out_request_code, want.out_command_data, want.last);
            $display("      got  kind=%0d prio=%0b code=%02h data=%016h last=%0b",
                     got.result_kind, got.from_priority, got.out_request_code,
                     got.out_command_data, got.last);
         end
      endfunction

      // Called once per accepted result.
      function void check_result(tlpcq_pkg::rsp_payload_type got);
         tlpcq_pkg::rsp_payload_type want;
         bit              bad;
         if (owed_results.size() == 0) begin
            report_mismatch("result with nothing owed", '0, got);
            return;
         end
         want = owed_results.pop_front();
         results++;
         kind_count[want.result_kind]++;
         bad = (got.result_kind !== want.result_kind)
            || (got.from_priority !== want.from_priority)
            || (got.out_request_code !== want.out_request_code)
            || (got.out_command_data !== want.out_command_data)
            || (got.last !== want.last);
         if (bad)
            report_mismatch("result differs", want, got);
      endfunction

      function void close_out();
         if (owed_results.size() != 0) begin
            mismatches += owed_results.size();
            $display("%0d results never arrived", owed_results.size());
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // Clock, reset and the block itself
   // ---------------------------------------------------------------------
   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   tlpcq_pkg::req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   tlpcq_pkg::rsp_payload_type rsp_payload;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   two_level_priority_command_queue_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   dispatch_scoreboard sb = new;

   // Idle rates in percent; changed by the stimulus between phases.
   int unsigned req_idle_pct  = 29;
   int unsigned rsp_idle_pct  = 58;
   int unsigned requests_sent = 0;

   // Long receiver hold-off, so the output register stays full and the block
   // has to push back on the request side while requests keep coming.
   bit   hold_off_armed = 1'b0;
   logic long_hold      = 1'b0;

   initial begin : receiver_hold_off
      int unsigned held;
      wait (hold_off_armed);
      @(posedge clock);
      long_hold <= 1'b1;
      for (held = 0; held < 120; held++)
         @(posedge clock);
      long_hold <= 1'b0;
   end

   // Result side: sample the handshake as the block saw it at this edge, then
   // decide the stall for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_payload);
      rsp_stall <= long_hold || ($urandom_range(99) < rsp_idle_pct);
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Holds valid and payload until the block takes the request; random gaps
   // go in front of it so idle cycles land in every phase of a service tick.
   task automatic send_request(input tlpcq_pkg::req_payload_type req);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= req;
      do @(posedge clock); while (req_stall);
      sb.note_request(req);
      requests_sent++;
   endtask

   task automatic enqueue_cmd(input bit prio, input logic [7:0] code,
                              input logic [63:0] data);
      tlpcq_pkg::req_payload_type req;
      req              = '0;
      req.opcode       = tlpcq_pkg::OP_ENQUEUE;
      req.is_priority  = prio;
      req.request_code = code;
      req.command_data = data;
      send_request(req);
   endtask

   // Service ticks carry random leftovers in the unused fields; the block
   // must ignore them.
   task automatic service_tick();
      tlpcq_pkg::req_payload_type req;
      req.opcode       = tlpcq_pkg::OP_SERVICE;
      req.is_priority  = 1'($urandom_range(1));
      req.request_code = 8'($urandom_range(255));
      req.command_data = {$urandom, $urandom};
      send_request(req);
   endtask

   function automatic logic [63:0] pick_data();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [7:0] pick_code();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Single enqueues, mostly general, so the general ring fills and drops, with
   // priority bursts that fill the small ring and service ticks in between.
   task automatic random_traffic(input int unsigned count);
      int unsigned stop_at, sel, burst, k;
      stop_at = requests_sent + count;
      while (requests_sent < stop_at) begin
         sel = $urandom_range(99);
         if (sel < 14) begin
            service_tick();
         end else if (sel < 26) begin
            burst = $urandom_range(10, 4);
            for (k = 0; k < burst; k++)
               enqueue_cmd(1'b1, pick_code(), pick_data());
         end else begin
            enqueue_cmd($urandom_range(99) < 25, pick_code(), pick_data());
         end
      end
   endtask

   initial begin : stimulus
      int unsigned k;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      service_tick();                                  // both rings empty
      enqueue_cmd(1'b0, 8'h00, 64'h0);                 // general, all zero
      enqueue_cmd(1'b0, 8'hff, '1);                    // general, all ones
      for (k = 0; k < PRIO_SLOTS + 1; k++)             // fill priority, then drop
         enqueue_cmd(1'b1, 8'h01 << (k % 8), 64'h8000_0000_0000_0001 << k);
      service_tick();                                  // full drain plus one general
      service_tick();                                  // last general entry only
      service_tick();                                  // empty again
      for (k = 0; k < 3; k++)                          // move the priority head on
         enqueue_cmd(1'b1, 8'h10 + 8'(k), {32'hcafe_0000 + k, 32'h0});
      service_tick();
      for (k = 0; k < 6; k++)                          // tail wraps round the ring
         enqueue_cmd(1'b1, 8'h20 + 8'(k), ~64'h0 - k);
      service_tick();

      // --- random part, three idling phases ---
      random_traffic(60);
      req_idle_pct = 58;
      rsp_idle_pct = 29;
      random_traffic(60);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      random_traffic(45);
      // back-pressure: receiver holds off while general enqueues keep arriving
      hold_off_armed = 1'b1;
      for (k = 0; k < 30; k++)
         enqueue_cmd(1'b0, pick_code(), pick_data());
      service_tick();
      req_valid <= 1'b0;

      // --- drain and close ---
      while (sb.outstanding() != 0)
         @(posedge clock);
      repeat (TICK_CYCLES + 8) @(posedge clock);
      sb.close_out();
      $display("Sent %0d requests and checked %0d results, incl. a long receiver hold-off",
               requests_sent, sb.results);
      $display("  enqueued %0d, dropped %0d, dispatched %0d, empty ticks %0d",
               sb.kind_count[tlpcq_pkg::KIND_ENQUEUED], sb.kind_count[tlpcq_pkg::KIND_DROPPED],
               sb.kind_count[tlpcq_pkg::KIND_DISPATCHED],
               sb.kind_count[tlpcq_pkg::KIND_NOTHING]);
      if (sb.mismatches == 0) begin
         $display("[two_level_priority_command_queue_top] OK");
      end else begin
         $display("%0d mismatches in total", sb.mismatches);
         $display("[two_level_priority_command_queue_top] ERROR");
      end
      $finish;
   end

   // Run limit: far beyond the slowest legal run.
   initial begin : watchdog
      #3_000_000;
      $display("Timed out with %0d results still owed", sb.outstanding());
      $display("[two_level_priority_command_queue_top] ERROR");
      $finish;
   end

endmodule

### files.f
rtl/core/tlpcq_pkg.sv
rtl/core/tlpcq_ctrl.sv
rtl/core/tlpcq_dp.sv
rtl/core/two_level_priority_command_queue_top.sv
dv/tb_top.sv
